### rtl/csm_pkg.sv
package csm_pkg;

    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam int IN_DEPTH         = 4;
    localparam int OUT_DEPTH        = 8;

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_NONZERO   = 2'd1;
    localparam logic [1:0] OP_EMPTY_ROW = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    // register index is paddr[2]; byte-lane bits are ignored
    localparam logic REG_ROW_COUNT     = 1'b0;
    localparam logic REG_VECTOR_LENGTH = 1'b1;

    localparam logic [15:0] ROW_COUNT_RST     = 16'd1;
    localparam logic [10:0] VECTOR_LENGTH_RST = 11'd1024;

    localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

    typedef enum logic [1:0] {
        K_LOAD,
        K_MAC,
        K_CLOSE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [9:0]         index;
        logic signed [31:0] value;
        logic               last;
        logic               col_ok;
    } t_cmd;

    typedef struct packed {
        logic signed [47:0] row_sum;
        logic [15:0]        row_index;
        logic               last_row;
        logic               column_error;
        logic               saturated;
    } t_res;

endpackage

### rtl/csm_ram.sv
module csm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = csm_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/csm_fifo.sv
module csm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    // DEPTH must be a power of two so the pointers wrap on their own
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + PW'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + PW'(1) : r_rptr;
        n_count = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### rtl/csm_front.sv
module csm_front #(
    parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [1:0]         i_op,
    input  logic [9:0]         i_index,
    input  logic signed [31:0] i_value,
    input  logic               i_last_in_row,
    input  logic [10:0]        i_vector_length,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output csm_pkg::t_cmd      o_cmd
);

    localparam int QCW = $clog2(csm_pkg::IN_DEPTH + 1);

    csm_pkg::t_cmd     cmd;
    logic              keep;
    logic              in_depth;
    logic [QCW-1:0]    q_count;
    logic [$bits(csm_pkg::t_cmd)-1:0] q_rdata;

    assign in_depth = ({7'd0, i_index} < 17'(VECTOR_DEPTH));

    // op 3 and loads past the store are dropped here
    always_comb begin
        cmd.kind   = csm_pkg::K_CLOSE;
        cmd.index  = i_index;
        cmd.value  = i_value;
        cmd.last   = i_last_in_row;
        cmd.col_ok = in_depth && ({1'b0, i_index} < i_vector_length);
        keep       = 1'b0;
        unique case (i_op)
            csm_pkg::OP_LOAD: begin
                cmd.kind = csm_pkg::K_LOAD;
                keep     = in_depth;
            end
            csm_pkg::OP_NONZERO: begin
                cmd.kind = csm_pkg::K_MAC;
                keep     = 1'b1;
            end
            csm_pkg::OP_EMPTY_ROW: begin
                cmd.kind = csm_pkg::K_CLOSE;
                keep     = 1'b1;
            end
            csm_pkg::OP_UNUSED: begin
                keep = 1'b0;
            end
        endcase
    end

    csm_fifo #(
        .WIDTH ($bits(csm_pkg::t_cmd)),
        .DEPTH (csm_pkg::IN_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_wdata (cmd),
        .i_pop   (i_pop),
        .o_rdata (q_rdata),
        .o_full  (o_full),
        .o_empty (o_empty),
        .o_count (q_count)
    );

    assign o_cmd = csm_pkg::t_cmd'(q_rdata);

endmodule

### rtl/csm_back.sv
module csm_back #(
    parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  csm_pkg::t_cmd                            i_cmd,
    input  logic                                     i_empty,
    input  logic [$clog2(csm_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    input  logic [15:0]                              i_row_count,
    output logic                                     o_pop,
    output logic                                     o_res_push,
    output csm_pkg::t_res                            o_res
);

    localparam int AW = $clog2(VECTOR_DEPTH);
    localparam int CW = $clog2(csm_pkg::OUT_DEPTH + 1);

    logic [AW-1:0]      addr;
    logic [31:0]        rdata;
    logic [CW:0]        used;

    // stage B: store read in flight
    logic               r_b_valid;
    csm_pkg::t_kind     r_b_kind;
    logic               r_b_col_ok;
    logic               r_b_last;
    logic signed [31:0] r_b_value;

    // stage C: product ready, accumulate
    logic               r_c_valid;
    csm_pkg::t_kind     r_c_kind;
    logic               r_c_col_ok;
    logic               r_c_last;
    logic signed [63:0] r_c_prod;

    logic signed [63:0] r_acc, n_acc;
    logic [15:0]        r_row, n_row;
    logic               r_err, n_err;

    // stage D: closed row, clip to 48 bits
    logic               r_d_valid, n_d_valid;
    logic signed [63:0] r_d_sum, n_d_sum;
    logic [15:0]        r_d_row, n_d_row;
    logic               r_d_last, n_d_last;
    logic               r_d_err, n_d_err;

    logic signed [63:0] delta, raw_sum, sat_sum;
    logic               is_mac, close, is_last_row, row_err;
    logic [16:0]        sum_hi;
    logic               clip;

    // only pop when every beat in flight is sure of a slot in the result queue
    assign used  = {1'b0, i_out_count} + (CW+1)'(r_b_valid) + (CW+1)'(r_c_valid)
                 + (CW+1)'(r_d_valid);
    assign o_pop = !i_empty && (used < (CW+1)'(csm_pkg::OUT_DEPTH));
    assign addr  = AW'(i_cmd.index);

    csm_ram #(
        .WIDTH (32),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (o_pop && (i_cmd.kind == csm_pkg::K_LOAD)),
        .i_waddr (addr),
        .i_wdata (i_cmd.value),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= o_pop;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_kind   <= i_cmd.kind;
        r_b_col_ok <= i_cmd.col_ok;
        r_b_last   <= i_cmd.last;
        r_b_value  <= i_cmd.value;
        r_c_kind   <= r_b_kind;
        r_c_col_ok <= r_b_col_ok;
        r_c_last   <= r_b_last;
        r_c_prod   <= r_b_value * $signed(rdata);
    end

    always_comb begin
        is_mac = (r_c_kind == csm_pkg::K_MAC);
        // arithmetic shift of the Q32.32 product is the floor to Q48.16
        delta  = (is_mac && r_c_col_ok) ? (r_c_prod >>> 16) : 64'sd0;
        raw_sum = r_acc + delta;
        if ((r_acc[63] == delta[63]) && (raw_sum[63] != r_acc[63])) begin
            sat_sum = r_acc[63] ? csm_pkg::ACC_MIN : csm_pkg::ACC_MAX;
        end else begin
            sat_sum = raw_sum;
        end
        close       = (r_c_kind == csm_pkg::K_CLOSE) || (is_mac && r_c_last);
        row_err     = r_err || (is_mac && !r_c_col_ok);
        is_last_row = (r_row == (i_row_count - 16'd1));

        n_acc     = r_acc;
        n_err     = r_err;
        n_row     = r_row;
        n_d_valid = 1'b0;
        n_d_sum   = sat_sum;
        n_d_row   = r_row;
        n_d_last  = is_last_row;
        n_d_err   = row_err;
        if (r_c_valid && (r_c_kind != csm_pkg::K_LOAD)) begin
            if (close) begin
                n_d_valid = 1'b1;
                n_acc     = 64'sd0;
                n_err     = 1'b0;
                n_row     = is_last_row ? 16'd0 : r_row + 16'd1;
            end else begin
                n_acc = sat_sum;
                n_err = row_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= 64'sd0;
            r_err     <= 1'b0;
            r_row     <= 16'd0;
            r_d_valid <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_err     <= n_err;
            r_row     <= n_row;
            r_d_valid <= n_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_d_valid) begin
            r_d_sum  <= n_d_sum;
            r_d_row  <= n_d_row;
            r_d_last <= n_d_last;
            r_d_err  <= n_d_err;
        end
    end

    assign sum_hi = r_d_sum[63:47];
    assign clip   = (sum_hi != '0) && (sum_hi != '1);

    always_comb begin
        o_res_push         = r_d_valid;
        o_res.row_sum      = clip ? (r_d_sum[63] ? csm_pkg::SUM_MIN : csm_pkg::SUM_MAX)
                                  : r_d_sum[47:0];
        o_res.row_index    = r_d_row;
        o_res.last_row     = r_d_last;
        o_res.column_error = r_d_err;
        o_res.saturated    = clip;
    end

endmodule

### rtl/csr_sparse_matvec.sv
// A closing beat reaches the result ports after it has passed through the input queue,
// store read, multiply, accumulate and clip into the result queue.
// Throughput: one beat per cycle while the result queue has room for every beat in flight,
// set by the single multiply-accumulate path; loads and nonzeros may interleave freely.
// Reset (synchronous, active low) empties both queues and clears the accumulator,
// row counter and error flag; row_count resets to 1, vector_length to 1024.
module csr_sparse_matvec #(
    parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_op,
    input  logic [9:0]         i_index,
    input  logic signed [31:0] i_value,
    input  logic               i_last_in_row,

    output logic               empty,
    input  logic               pop,
    output logic signed [47:0] o_row_sum,
    output logic [15:0]        o_row_index,
    output logic               o_last_row,
    output logic               o_column_error,
    output logic               o_saturated
);

    localparam int OCW = $clog2(csm_pkg::OUT_DEPTH + 1);

    logic [15:0]   r_row_count;
    logic [10:0]   r_vector_length;
    logic          cfg_wr;

    csm_pkg::t_cmd cmd;
    logic          cmd_empty;
    logic          cmd_pop;
    logic          res_push;
    csm_pkg::t_res res_in, res_out;
    logic [$bits(csm_pkg::t_res)-1:0] res_rdata;
    logic          res_full;
    logic [OCW-1:0] res_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= csm_pkg::ROW_COUNT_RST;
            r_vector_length <= csm_pkg::VECTOR_LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                csm_pkg::REG_ROW_COUNT:     r_row_count     <= pwdata[15:0];
                csm_pkg::REG_VECTOR_LENGTH: r_vector_length <= pwdata[10:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            csm_pkg::REG_ROW_COUNT:     prdata = {16'd0, r_row_count};
            csm_pkg::REG_VECTOR_LENGTH: prdata = {21'd0, r_vector_length};
        endcase
    end

    csm_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_op            (i_op),
        .i_index         (i_index),
        .i_value         (i_value),
        .i_last_in_row   (i_last_in_row),
        .i_vector_length (r_vector_length),
        .i_pop           (cmd_pop),
        .o_full          (full),
        .o_empty         (cmd_empty),
        .o_cmd           (cmd)
    );

    csm_back #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_empty     (cmd_empty),
        .i_out_count (res_count),
        .i_row_count (r_row_count),
        .o_pop       (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // back end never pushes without a free slot, so res_full is never hit
    csm_fifo #(
        .WIDTH ($bits(csm_pkg::t_res)),
        .DEPTH (csm_pkg::OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_full  (res_full),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign res_out        = csm_pkg::t_res'(res_rdata);
    assign o_row_sum      = res_out.row_sum;
    assign o_row_index    = res_out.row_index;
    assign o_last_row     = res_out.last_row;
    assign o_column_error = res_out.column_error;
    assign o_saturated    = res_out.saturated;

endmodule

### tb/csm_checker.sv
module csm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic [31:0]        i_prdata,
    input  logic               i_pready,

    input  logic               i_push,
    input  logic               i_full,
    input  logic [1:0]         i_op,
    input  logic [9:0]         i_index,
    input  logic signed [31:0] i_value,
    input  logic               i_last_in_row,

    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [47:0] i_row_sum,
    input  logic [15:0]        i_row_index,
    input  logic               i_last_row,
    input  logic               i_column_error,
    input  logic               i_saturated,

    output int                 o_fail_count,
    output int                 o_pending
);
    import csm_pkg::*;

    logic [31:0]        vec_mem [VECTOR_DEPTH_DEF];
    logic signed [63:0] acc;
    logic [15:0]        row_num;
    logic               row_err;
    logic [15:0]        cfg_rows;
    logic [10:0]        cfg_vlen;
    t_res               sums_due [$];

    task automatic mismatch(input string fld, input longint want, input longint got);
        $error("%s: expected %0d, got %0d", fld, want, got);
        o_fail_count++;
    endtask

    // clip to Q32.16, queue the row result and move to the next row
    task automatic close_row();
        t_res r;
        r.saturated = 1'b0;
        if (acc > SUM_MAX) begin
            r.row_sum   = SUM_MAX;
            r.saturated = 1'b1;
        end else if (acc < SUM_MIN) begin
            r.row_sum   = SUM_MIN;
            r.saturated = 1'b1;
        end else begin
            r.row_sum = acc[47:0];
        end
        r.row_index    = row_num;
        r.last_row     = (row_num == cfg_rows - 16'd1);
        r.column_error = row_err;
        sums_due.push_back(r);
        acc     = '0;
        row_err = 1'b0;
        row_num = r.last_row ? 16'd0 : row_num + 16'd1;
    endtask

    task automatic take_beat(input logic [1:0] op, input logic [9:0] idx,
                             input logic signed [31:0] val, input logic last);
        logic signed [31:0] elem;
        logic signed [63:0] prod;
        logic signed [64:0] total;
        case (op)
            OP_LOAD: begin
                vec_mem[idx] = val;
            end
            OP_NONZERO: begin
                if (idx < cfg_vlen) begin
                    elem  = vec_mem[idx];
                    prod  = val * elem;
                    // Q32.32 -> Q48.16, floor, then saturating 64-bit add
                    total = acc + (prod >>> 16);
                    if (total > ACC_MAX)
                        acc = ACC_MAX;
                    else if (total < ACC_MIN)
                        acc = ACC_MIN;
                    else
                        acc = total[63:0];
                end else begin
                    row_err = 1'b1;
                end
                if (last)
                    close_row();
            end
            OP_EMPTY_ROW: begin
                close_row();
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_res        want;
        logic [31:0] reg_val;
        if (!i_rst_n) begin
            acc      = '0;
            row_num  = '0;
            row_err  = 1'b0;
            cfg_rows = ROW_COUNT_RST;
            cfg_vlen = VECTOR_LENGTH_RST;
            sums_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[2])
                        REG_ROW_COUNT:     cfg_rows = i_pwdata[15:0];
                        REG_VECTOR_LENGTH: cfg_vlen = i_pwdata[10:0];
                    endcase
                end else begin
                    reg_val = (i_paddr[2] == REG_ROW_COUNT) ? {16'd0, cfg_rows}
                                                            : {21'd0, cfg_vlen};
                    if (i_prdata !== reg_val)
                        mismatch("prdata", reg_val, i_prdata);
                end
            end

            // result side first, so a beat pushed this edge cannot hide a stray result
            if (i_pop && !i_empty) begin
                if (sums_due.size() == 0) begin
                    $error("result beat with nothing expected, row_index %0d", i_row_index);
                    o_fail_count++;
                end else begin
                    want = sums_due.pop_front();
                    if (i_row_sum !== want.row_sum)
                        mismatch("row_sum", $signed(want.row_sum), $signed(i_row_sum));
                    if (i_row_index !== want.row_index)
                        mismatch("row_index", want.row_index, i_row_index);
                    if (i_last_row !== want.last_row)
                        mismatch("last_row", want.last_row, i_last_row);
                    if (i_column_error !== want.column_error)
                        mismatch("column_error", want.column_error, i_column_error);
                    if (i_saturated !== want.saturated)
                        mismatch("saturated", want.saturated, i_saturated);
                end
            end

            if (i_push && !i_full)
                take_beat(i_op, i_index, i_value, i_last_in_row);
        end
        o_pending = sums_due.size();
    end

endmodule

### tb/tb_top.sv
module tb_top;
    import csm_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PIPE_CYCLES  = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BEATS  = 133;
    localparam int N_PHASES     = 7;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [2:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic               push          = 1'b0;
    logic               full;
    logic [1:0]         i_op          = OP_LOAD;
    logic [9:0]         i_index       = '0;
    logic signed [31:0] i_value       = '0;
    logic               i_last_in_row = 1'b0;

    logic               empty;
    logic               pop = 1'b0;
    logic signed [47:0] o_row_sum;
    logic [15:0]        o_row_index;
    logic               o_last_row;
    logic               o_column_error;
    logic               o_saturated;

    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    bit                 hold_req    = 1'b0;
    bit                 tx_burst    = 1'b0;
    bit                 rx_burst    = 1'b0;
    bit                 loaded [VECTOR_DEPTH_DEF];
    int                 loaded_cols [$];
    int                 vlen_now    = VECTOR_LENGTH_RST;

    int rows_tab [N_PHASES] = '{1, 65535, 0, 5, 3, 2, 7};
    int vlen_tab [N_PHASES] = '{1024, 512, 2047, 1, 0, 1000, 100};

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    csr_sparse_matvec uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_last_in_row  (i_last_in_row),
        .empty          (empty),
        .pop            (pop),
        .o_row_sum      (o_row_sum),
        .o_row_index    (o_row_index),
        .o_last_row     (o_last_row),
        .o_column_error (o_column_error),
        .o_saturated    (o_saturated)
    );

    csm_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .i_push         (push),
        .i_full         (full),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_last_in_row  (i_last_in_row),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_row_sum      (o_row_sum),
        .i_row_index    (o_row_index),
        .i_last_row     (o_last_row),
        .i_column_error (o_column_error),
        .i_saturated    (o_saturated),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // runs from a falling edge to the falling edge after the beat is taken
    task automatic send_beat(input logic [1:0] op, input logic [9:0] idx,
                             input logic [31:0] val, input logic last);
        int gap;
        bit ok;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push          <= 1'b1;
        i_op          <= op;
        i_index       <= idx;
        i_value       <= val;
        i_last_in_row <= last;
        do begin
            ok = !full;
            @(posedge i_clk);
            if (!ok)
                @(negedge i_clk);
        end while (!ok);
        @(negedge i_clk);
    endtask

    task automatic load_elem(input logic [9:0] idx, input logic [31:0] val);
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_cols.push_back(idx);
        end
        send_beat(OP_LOAD, idx, val, 1'($urandom));
    endtask

    // back-to-back transfers: an access is followed directly by the next setup
    task automatic apb_access(input bit wr, input logic sel, input logic [31:0] val);
        logic [31:0] data;
        bit          ok;
        data = $urandom;
        if (sel == REG_ROW_COUNT)
            data[15:0] = val[15:0];
        else
            data[10:0] = val[10:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            ok = pready;
            @(posedge i_clk);
            if (!ok)
                @(negedge i_clk);
        end while (!ok);
        @(negedge i_clk);
    endtask

    task automatic set_regs(input int rows, input int vlen);
        apb_access(1'b1, REG_ROW_COUNT, rows);
        apb_access(1'b1, REG_VECTOR_LENGTH, vlen);
        vlen_now = vlen & 32'h7FF;
        apb_access(1'b0, REG_ROW_COUNT, '0);
        apb_access(1'b0, REG_VECTOR_LENGTH, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for every row result, then let the pipe empty of silent beats
    task automatic settle(input int extra);
        push <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0001_0000;
                endcase
            end
            1: begin
                v = $urandom_range(0, 32'h000F_FFFF);
                v = v - 32'h0008_0000;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // in-range columns only hit loaded entries; bad ones lie at or past vector_length
    function automatic logic [9:0] pick_column(input bit bad);
        logic [9:0] c;
        if (bad && vlen_now < VECTOR_DEPTH_DEF)
            return 10'($urandom_range(VECTOR_DEPTH_DEF - 1, vlen_now));
        c = 10'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
        for (int t = 0; t < 4 && c >= vlen_now; t++)
            c = 10'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
        return c;
    endfunction

    task automatic run_phase(input int beats, input bit burst0);
        int r;
        tx_burst = burst0;
        for (int n = 0; n < beats; n++) begin
            if ($urandom_range(0, 31) == 0)
                tx_burst = !tx_burst;
            r = $urandom_range(0, 99);
            if (r < 18)
                load_elem(10'($urandom), rand_value());
            else if (r < 82)
                send_beat(OP_NONZERO, pick_column($urandom_range(0, 9) == 0), rand_value(),
                          $urandom_range(0, 3) == 0);
            else if (r < 92)
                send_beat(OP_EMPTY_ROW, 10'($urandom), $urandom, 1'($urandom));
            else
                send_beat(OP_UNUSED, 10'($urandom), $urandom, 1'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, floor rounding, both saturations, empty rows, unused op
        set_regs(4, 1024);
        load_elem(10'd0, 32'h7FFF_FFFF);
        load_elem(10'd1023, 32'h8000_0000);
        load_elem(10'd1, 32'h0001_0000);
        load_elem(10'd2, 32'hFFFF_FFFF);
        send_beat(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
        send_beat(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b1);
        send_beat(OP_NONZERO, 10'd2, 32'h0000_0001, 1'b1);
        send_beat(OP_EMPTY_ROW, 10'd0, 32'h0, 1'b0);
        send_beat(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_NONZERO, 10'd1, 32'h0003_0000, 1'b0);
        send_beat(OP_EMPTY_ROW, 10'h3FF, 32'h8000_0000, 1'b1);
        for (int k = 0; k < 3; k++)
            send_beat(OP_NONZERO, 10'd0, 32'h8000_0000, k == 2);
        settle(PIPE_CYCLES);

        // short vector: out-of-range columns flag the row but it still closes
        set_regs(2, 3);
        send_beat(OP_NONZERO, 10'd5, 32'h1234_5678, 1'b0);
        send_beat(OP_NONZERO, 10'd1, 32'h0001_0000, 1'b1);
        send_beat(OP_NONZERO, 10'd1000, 32'h7FFF_FFFF, 1'b1);
        settle(PIPE_CYCLES);

        for (int p = 0; p < N_PHASES; p++) begin
            set_regs(rows_tab[p], vlen_tab[p]);
            // backpressure: result side stalls long while beats keep coming
            if (p == 1)
                hold_req = 1'b1;
            run_phase(PHASE_BEATS, p == 1);
            settle(PIPE_CYCLES);
        end

        settle(DRAIN_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int gap;
        bit ok;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 10);
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            pop <= 1'b1;
            do begin
                ok = !empty;
                @(posedge i_clk);
                if (!ok)
                    @(negedge i_clk);
            end while (!ok);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
